// ===== rtl/stg2_pkg.sv =====
// shared constants, types and pixel helpers of the spatiotemporal gradient block
package stg2_pkg;

    localparam int PIXEL_BITS  = 8;
    localparam int PAIR_BITS   = 2 * PIXEL_BITS;
    localparam int MAX_WIDTH   = 1024;
    localparam int MAX_HEIGHT  = 4096;
    localparam int COL_BITS    = $clog2(MAX_WIDTH);
    localparam int ROW_BITS    = $clog2(MAX_HEIGHT);
    localparam int WIDTH_BITS  = 11;
    localparam int HEIGHT_BITS = 13;
    localparam int CFG_BITS    = 13;
    localparam int GRAD_BITS   = 11;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = WIDTH_BITS'(640);
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = HEIGHT_BITS'(480);

    typedef enum logic {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    typedef logic [PAIR_BITS-1:0] t_pair;

    typedef struct packed {
        logic                emit;
        logic                frame_end;
        logic [COL_BITS-1:0] col;
    } t_pos;

    function automatic logic signed [GRAD_BITS-1:0] f_first(input t_pair p);
        return GRAD_BITS'(p[PAIR_BITS-1:PIXEL_BITS]);
    endfunction

    function automatic logic signed [GRAD_BITS-1:0] f_second(input t_pair p);
        return GRAD_BITS'(p[PIXEL_BITS-1:0]);
    endfunction

    function automatic logic signed [GRAD_BITS-1:0] f_sum(input t_pair p);
        return f_first(p) + f_second(p);
    endfunction

endpackage

// ===== rtl/stg2_ram.sv =====
// generic single-port-write, registered-read ram
module stg2_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/stg2_pos.sv =====
// frame size registers and raster position counters
module stg2_pos (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  stg2_pkg::t_cfg_reg           i_cfg_index,
    input  logic [stg2_pkg::CFG_BITS-1:0] i_cfg_data,
    input  logic                         i_adv,
    output stg2_pkg::t_pos               o_pos,
    output logic [stg2_pkg::COL_BITS-1:0] o_col_next
);
    import stg2_pkg::*;

    logic [WIDTH_BITS-1:0]  r_frame_width;
    logic [HEIGHT_BITS-1:0] r_frame_height;
    logic [COL_BITS-1:0]    r_col;
    logic [COL_BITS-1:0]    n_col;
    logic [ROW_BITS-1:0]    r_row;
    logic [ROW_BITS-1:0]    n_row;
    logic [WIDTH_BITS-1:0]  w_last;
    logic [HEIGHT_BITS-1:0] h_last;
    logic                   last_col;
    logic                   last_row;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= WIDTH_RESET;
            r_frame_height <= HEIGHT_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[WIDTH_BITS-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[HEIGHT_BITS-1:0];
                default: ;
            endcase
        end
    end

    // last column and row index after clamping
    always_comb begin
        if (r_frame_width == '0) begin
            w_last = '0;
        end else if (r_frame_width > WIDTH_BITS'(MAX_WIDTH)) begin
            w_last = WIDTH_BITS'(MAX_WIDTH - 1);
        end else begin
            w_last = r_frame_width - WIDTH_BITS'(1);
        end
        if (r_frame_height == '0) begin
            h_last = '0;
        end else if (r_frame_height > HEIGHT_BITS'(MAX_HEIGHT)) begin
            h_last = HEIGHT_BITS'(MAX_HEIGHT - 1);
        end else begin
            h_last = r_frame_height - HEIGHT_BITS'(1);
        end
    end

    assign last_col = WIDTH_BITS'(r_col) >= w_last;
    assign last_row = HEIGHT_BITS'(r_row) >= h_last;

    always_comb begin
        n_col = r_col;
        n_row = r_row;
        if (i_adv) begin
            if (last_col) begin
                n_col = '0;
                n_row = last_row ? '0 : r_row + ROW_BITS'(1);
            end else begin
                n_col = r_col + COL_BITS'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    assign o_pos.emit      = (r_col != '0) && (r_row != '0) && (w_last != '0) && (h_last != '0);
    assign o_pos.frame_end = last_col && last_row;
    assign o_pos.col       = r_col;
    assign o_col_next      = n_col;

endmodule

// ===== rtl/stg2_grad.sv =====
// gradient arithmetic of one 2x2x2 cube and the result register
module stg2_grad (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_load,
    input  stg2_pkg::t_pos                      i_pos,
    input  stg2_pkg::t_pair                     i_ul,
    input  stg2_pkg::t_pair                     i_ur,
    input  stg2_pkg::t_pair                     i_ll,
    input  stg2_pkg::t_pair                     i_lr,
    input  logic                                i_stall,
    output logic                                o_valid,
    output logic                                o_busy,
    output logic signed [stg2_pkg::GRAD_BITS-1:0] o_grad_x,
    output logic signed [stg2_pkg::GRAD_BITS-1:0] o_grad_y,
    output logic signed [stg2_pkg::GRAD_BITS-1:0] o_grad_t,
    output logic                                o_frame_end
);
    import stg2_pkg::*;

    logic signed [GRAD_BITS-1:0] s_ul, s_ur, s_ll, s_lr;
    logic signed [GRAD_BITS-1:0] gx, gy, gt;
    logic signed [GRAD_BITS-1:0] r_gx, r_gy, r_gt;
    logic                        r_frame_end;
    logic                        r_valid;

    assign s_ul = f_sum(i_ul);
    assign s_ur = f_sum(i_ur);
    assign s_ll = f_sum(i_ll);
    assign s_lr = f_sum(i_lr);

    assign gx = (s_ur + s_lr) - (s_ul + s_ll);
    assign gy = (s_ll + s_lr) - (s_ul + s_ur);
    assign gt = (f_second(i_ul) + f_second(i_ur) + f_second(i_ll) + f_second(i_lr))
              - (f_first(i_ul) + f_first(i_ur) + f_first(i_ll) + f_first(i_lr));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= i_pos.emit;
        end else if (!i_stall) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load && i_pos.emit) begin
            r_gx        <= gx;
            r_gy        <= gy;
            r_gt        <= gt;
            r_frame_end <= i_pos.frame_end;
        end
    end

    assign o_valid     = r_valid;
    assign o_busy      = r_valid && i_stall;
    assign o_grad_x    = r_gx;
    assign o_grad_y    = r_gy;
    assign o_grad_t    = r_gt;
    assign o_frame_end = r_frame_end;

endmodule

// ===== rtl/spatiotemporal_gradient_2x2x2_top.sv =====
// top level of the spatiotemporal gradient block
// Takes one word per clock: a pixel pair (earlier and later frame) in raster order, and
// gives x, y and time derivatives of each 2x2x2 cube times four, one result word for each
// pixel at column >= 1 and row >= 1. A new word is taken every cycle unless the result
// register holds a stalled word; a result appears in the cycle after its input word.
// The line store is a single ram read every cycle at the next column, with a bypass for a
// write to the same address, so the ram port sets the one-word-per-cycle figure. Frame size
// must be written only while idle (unenforced); it acts at once, position counters kept.
module spatiotemporal_gradient_2x2x2_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  stg2_pkg::t_cfg_reg                  i_cfg_index,
    input  logic [stg2_pkg::CFG_BITS-1:0]       i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [stg2_pkg::PIXEL_BITS-1:0]     i_pixel_first,
    input  logic [stg2_pkg::PIXEL_BITS-1:0]     i_pixel_second,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic signed [stg2_pkg::GRAD_BITS-1:0] o_grad_x,
    output logic signed [stg2_pkg::GRAD_BITS-1:0] o_grad_y,
    output logic signed [stg2_pkg::GRAD_BITS-1:0] o_grad_t,
    output logic                                o_frame_end
);
    import stg2_pkg::*;

    t_pos                 pos;
    logic [COL_BITS-1:0]  col_next;
    logic                 accept;
    logic                 busy;
    t_pair                cur;
    t_pair                up;
    t_pair                ram_q;
    logic                 r_byp;
    t_pair                r_byp_pair;
    logic [2*PAIR_BITS-1:0] r_left;

    assign cur     = {i_pixel_first, i_pixel_second};
    assign o_stall = busy;
    assign accept  = i_valid && !busy;

    stg2_pos u_pos (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_adv       (accept),
        .o_pos       (pos),
        .o_col_next  (col_next)
    );

    stg2_ram #(
        .WIDTH (PAIR_BITS),
        .DEPTH (MAX_WIDTH)
    ) u_row_store (
        .i_clk   (i_clk),
        .i_we    (accept),
        .i_waddr (pos.col),
        .i_wdata (cur),
        .i_raddr (col_next),
        .o_rdata (ram_q)
    );

    // same-address write and read in one cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_byp <= 1'b0;
        end else begin
            r_byp <= accept && (col_next == pos.col);
        end
        r_byp_pair <= cur;
    end

    assign up = r_byp ? r_byp_pair : ram_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_left <= '0;
        end else if (accept) begin
            r_left <= {up, cur};
        end
    end

    stg2_grad u_grad (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_load      (accept),
        .i_pos       (pos),
        .i_ul        (r_left[2*PAIR_BITS-1:PAIR_BITS]),
        .i_ur        (up),
        .i_ll        (r_left[PAIR_BITS-1:0]),
        .i_lr        (cur),
        .i_stall     (i_stall),
        .o_valid     (o_valid),
        .o_busy      (busy),
        .o_grad_x    (o_grad_x),
        .o_grad_y    (o_grad_y),
        .o_grad_t    (o_grad_t),
        .o_frame_end (o_frame_end)
    );

endmodule

// ===== test/spatiotemporal_gradient_2x2x2_top_test.sv =====
// testbench of the spatiotemporal gradient block: directed and random pixel streams against a predictor
module spatiotemporal_gradient_2x2x2_top_test;
    import stg2_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int SETTLE      = 4;

    typedef struct packed {
        logic signed [GRAD_BITS-1:0] grad_x;
        logic signed [GRAD_BITS-1:0] grad_y;
        logic signed [GRAD_BITS-1:0] grad_t;
        logic                        frame_end;
    } t_cube;

    logic                           i_clk = 1'b0;
    logic                           i_rst_n = 1'b0;
    logic                           i_cfg_we = 1'b0;
    t_cfg_reg                       i_cfg_index = CFG_FRAME_WIDTH;
    logic [CFG_BITS-1:0]            i_cfg_data = '0;
    logic                           i_valid = 1'b0;
    logic                           o_stall;
    logic [PIXEL_BITS-1:0]          i_pixel_first = '0;
    logic [PIXEL_BITS-1:0]          i_pixel_second = '0;
    logic                           o_valid;
    logic                           i_stall = 1'b0;
    logic signed [GRAD_BITS-1:0]    o_grad_x;
    logic signed [GRAD_BITS-1:0]    o_grad_y;
    logic signed [GRAD_BITS-1:0]    o_grad_t;
    logic                           o_frame_end;

    // predictor state
    logic [PAIR_BITS-1:0]   line_mem [MAX_WIDTH];
    bit                     line_filled [MAX_WIDTH];
    logic [2*PAIR_BITS-1:0] left_pairs = '0;
    int                     col_pos = 0;
    int                     row_pos = 0;
    logic [WIDTH_BITS-1:0]  width_reg = WIDTH_RESET;
    logic [HEIGHT_BITS-1:0] height_reg = HEIGHT_RESET;

    t_cube cube_q[$];
    t_cube want_cube;
    int    mismatches = 0;
    int    quiet_cycles = 0;
    int    pairs_sent = 0;
    bit    calm = 1'b0;

    spatiotemporal_gradient_2x2x2_top DUT (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_index    (i_cfg_index),
        .i_cfg_data     (i_cfg_data),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_pixel_first  (i_pixel_first),
        .i_pixel_second (i_pixel_second),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_grad_x       (o_grad_x),
        .o_grad_y       (o_grad_y),
        .o_grad_t       (o_grad_t),
        .o_frame_end    (o_frame_end)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic int active_width();
        int w;
        w = width_reg;
        if (w > MAX_WIDTH) w = MAX_WIDTH;
        if (w == 0) w = 1;
        return w;
    endfunction

    function automatic int active_height();
        int h;
        h = height_reg;
        if (h > MAX_HEIGHT) h = MAX_HEIGHT;
        if (h == 0) h = 1;
        return h;
    endfunction

    function automatic int earlier(input logic [PAIR_BITS-1:0] p);
        return int'(p[PAIR_BITS-1:PIXEL_BITS]);
    endfunction

    function automatic int later(input logic [PAIR_BITS-1:0] p);
        return int'(p[PIXEL_BITS-1:0]);
    endfunction

    // one accepted pixel pair: derivatives of the cube it closes, then window and counters
    function automatic void advance_gradient(input logic [PIXEL_BITS-1:0] first,
                                             input logic [PIXEL_BITS-1:0] second);
        int w, h, c, r, gx, gy, gt;
        bit last_c, last_r;
        logic [PAIR_BITS-1:0] cur, up, ul, ll;
        t_cube cube;
        w = active_width();
        h = active_height();
        c = col_pos;
        r = row_pos;
        last_c = (c >= w - 1);
        last_r = (r >= h - 1);
        cur = {first, second};
        up = line_mem[c];
        if (c >= 1 && r >= 1 && w >= 2 && h >= 2) begin
            ul = left_pairs[2*PAIR_BITS-1:PAIR_BITS];
            ll = left_pairs[PAIR_BITS-1:0];
            gx = earlier(up) + later(up) + earlier(cur) + later(cur)
               - earlier(ul) - later(ul) - earlier(ll) - later(ll);
            gy = earlier(ll) + later(ll) + earlier(cur) + later(cur)
               - earlier(ul) - later(ul) - earlier(up) - later(up);
            gt = later(ul) + later(up) + later(ll) + later(cur)
               - earlier(ul) - earlier(up) - earlier(ll) - earlier(cur);
            cube.grad_x = gx[GRAD_BITS-1:0];
            cube.grad_y = gy[GRAD_BITS-1:0];
            cube.grad_t = gt[GRAD_BITS-1:0];
            cube.frame_end = last_c && last_r;
            cube_q.push_back(cube);
        end
        left_pairs = {up, cur};
        line_mem[c] = cur;
        line_filled[c] = 1'b1;
        if (last_c) begin
            col_pos = 0;
            row_pos = last_r ? 0 : ((r + 1) & 12'hFFF);
        end else begin
            col_pos = (c + 1) & 10'h3FF;
        end
    endfunction

    // keeps a mid-frame width increase from reaching line store entries never written
    function automatic logic [WIDTH_BITS-1:0] safe_width(input int value);
        int lim, n;
        lim = (value > MAX_WIDTH) ? MAX_WIDTH : ((value == 0) ? 1 : value);
        if (row_pos == 0) return WIDTH_BITS'(value);
        n = 0;
        while (n < MAX_WIDTH && line_filled[n]) n++;
        return (lim <= n) ? WIDTH_BITS'(value) : WIDTH_BITS'(n);
    endfunction

    function automatic logic [PIXEL_BITS-1:0] pick_pixel(input int mode);
        case (mode)
            0: return PIXEL_BITS'($urandom_range(255));
            1: return $urandom_range(1) ? 8'hFF : 8'h00;
            default: return PIXEL_BITS'(112 + $urandom_range(31));
        endcase
    endfunction

    task automatic send_pair(input logic [PIXEL_BITS-1:0] first,
                             input logic [PIXEL_BITS-1:0] second);
        while (!calm && $urandom_range(99) < 27) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_pixel_first <= first;
        i_pixel_second <= second;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        advance_gradient(first, second);
        pairs_sent++;
    endtask

    task automatic drain_results(input int extra);
        i_valid <= 1'b0;
        do @(posedge i_clk); while (cube_q.size() != 0);
        repeat (extra) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_reg idx, input logic [CFG_BITS-1:0] value);
        drain_results(SETTLE);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        if (idx == CFG_FRAME_WIDTH) width_reg = value[WIDTH_BITS-1:0];
        else height_reg = value[HEIGHT_BITS-1:0];
    endtask

    task automatic set_width(input int value);
        write_reg(CFG_FRAME_WIDTH, {2'($urandom_range(3)), safe_width(value)});
    endtask

    task automatic complete_frame(input int mode);
        while (col_pos != 0 || row_pos != 0) send_pair(pick_pixel(mode), pick_pixel(mode));
    endtask

    task automatic send_square(input logic [PAIR_BITS-1:0] ul, input logic [PAIR_BITS-1:0] ur,
                               input logic [PAIR_BITS-1:0] dl, input logic [PAIR_BITS-1:0] dr);
        send_pair(ul[15:8], ul[7:0]);
        send_pair(ur[15:8], ur[7:0]);
        send_pair(dl[15:8], dl[7:0]);
        send_pair(dr[15:8], dr[7:0]);
    endtask

    task automatic test_directed_cubes();
        set_width(2);
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        send_square(16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF);
        send_square(16'hFFFF, 16'h0000, 16'hFFFF, 16'h0000);
        send_square(16'hFFFF, 16'hFFFF, 16'h0000, 16'h0000);
        send_square(16'h0000, 16'h0000, 16'hFFFF, 16'hFFFF);
        send_square(16'h00FF, 16'h00FF, 16'h00FF, 16'h00FF);
        send_square(16'hFF00, 16'hFF00, 16'hFF00, 16'hFF00);
    endtask

    // sizes of zero and one never give a word
    task automatic test_degenerate_sizes();
        set_width(0);
        repeat (3) send_pair(pick_pixel(0), pick_pixel(0));
        set_width(1);
        repeat (2) send_pair(pick_pixel(0), pick_pixel(0));
        write_reg(CFG_FRAME_HEIGHT, 13'd0);
        repeat (2) send_pair(pick_pixel(0), pick_pixel(0));
        set_width(5);
        write_reg(CFG_FRAME_HEIGHT, 13'd1);
        repeat (4) send_pair(pick_pixel(0), pick_pixel(0));
    endtask

    task automatic test_midframe_resize();
        set_width(6);
        write_reg(CFG_FRAME_HEIGHT, 13'd5);
        complete_frame(0);
        repeat (20) send_pair(pick_pixel(0), pick_pixel(0));
        set_width(3);
        repeat (10) send_pair(pick_pixel(0), pick_pixel(0));
        set_width(6);
        repeat (8) send_pair(pick_pixel(1), pick_pixel(0));
        write_reg(CFG_FRAME_HEIGHT, 13'd2);
        complete_frame(0);
    endtask

    task automatic test_extreme_sizes();
        set_width(2047);
        write_reg(CFG_FRAME_HEIGHT, 13'd8191);
        repeat (6) send_pair(pick_pixel(0), pick_pixel(0));
        set_width(2);
        write_reg(CFG_FRAME_HEIGHT, 13'd4096);
        repeat (8) send_pair(pick_pixel(2), pick_pixel(2));
        set_width(4);
        write_reg(CFG_FRAME_HEIGHT, 13'd3);
        complete_frame(1);
    endtask

    task automatic test_random_frames();
        int start, w, h, mode, frame_no, cut;
        start = pairs_sent;
        frame_no = 0;
        while (pairs_sent - start < 280) begin
            calm = (frame_no == 2 || frame_no == 3);
            if ($urandom_range(9) == 0) begin
                w = 20 + $urandom_range(44);
                h = 2 + $urandom_range(2);
            end else begin
                w = 2 + $urandom_range(10);
                h = 2 + $urandom_range(6);
            end
            mode = $urandom_range(2);
            set_width(w);
            write_reg(CFG_FRAME_HEIGHT, HEIGHT_BITS'(h));
            if ($urandom_range(4) == 0) begin
                // broken frame: resized partway through
                cut = 1 + $urandom_range(w * h - 2);
                repeat (cut) send_pair(pick_pixel(mode), pick_pixel(mode));
                if ($urandom_range(1)) set_width(2 + $urandom_range(10));
                else write_reg(CFG_FRAME_HEIGHT, HEIGHT_BITS'(2 + $urandom_range(6)));
            end else begin
                send_pair(pick_pixel(mode), pick_pixel(mode));
            end
            complete_frame(mode);
            frame_no++;
        end
        calm = 1'b0;
    endtask

    task automatic check_field(input string name, input integer want, input integer got);
        if (want !== got) begin
            mismatches++;
            $display("%0t: %s want %0d got %0d", $time, name, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (calm) i_stall <= 1'b0;
        else i_stall <= ($urandom_range(99) < 27);
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (cube_q.size() == 0) begin
                mismatches++;
                $display("%0t: unexpected word gx %0d gy %0d gt %0d", $time,
                         o_grad_x, o_grad_y, o_grad_t);
            end else begin
                want_cube = cube_q.pop_front();
                check_field("grad_x", integer'(want_cube.grad_x), integer'(o_grad_x));
                check_field("grad_y", integer'(want_cube.grad_y), integer'(o_grad_y));
                check_field("grad_t", integer'(want_cube.grad_t), integer'(o_grad_t));
                check_field("frame_end", integer'(want_cube.frame_end), integer'(o_frame_end));
            end
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        repeat (4) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed_cubes();
        test_degenerate_sizes();
        test_midframe_resize();
        test_extreme_sizes();
        test_random_frames();
        drain_results(8);
        if (mismatches == 0 && cube_q.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
